// ----- design/tdq_pkg.sv -----
// tdq_pkg: shared types, constants and codes of the timer event queue
// used by tdq_cell, tdq_chain and timer_dedup_event_queue; no dependencies
package tdq_pkg;

    localparam int QUEUE_DEPTH = 128;
    // one slot always stays free, so the row holds one cell less
    localparam int CELL_COUNT  = QUEUE_DEPTH - 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH);

    localparam logic KIND_POST = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

    localparam logic REG_TIMER_ID = 1'b0;
    localparam logic REG_EXIT_ID  = 1'b1;

    localparam logic FMT_POINTER = 1'b1;

    typedef enum logic [2:0] {
        ST_POSTED = 3'd0,
        ST_FULL   = 3'd1,
        ST_DUP    = 3'd2,
        ST_BAD_ID = 3'd3,
        ST_TAKEN  = 3'd4,
        ST_EMPTY  = 3'd5,
        ST_EXIT   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [15:0] event_id;
        logic [31:0] sequence_num;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [7:0]  category;
        logic        data_format;
        logic [31:0] dest_app;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_event_id;
        logic [31:0] out_sequence_num;
        logic [31:0] out_first_word;
        logic [31:0] out_second_word;
        logic [7:0]  out_category;
        logic        out_data_format;
        logic [31:0] out_dest_app;
        logic [6:0]  occupancy;
    } t_out_word;

    // one stored queue entry
    typedef struct packed {
        logic [15:0] event_id;
        logic [31:0] sequence_num;
        logic [31:0] first_word;
        logic [31:0] second_word;
        logic [7:0]  category;
        logic        data_format;
        logic [31:0] dest_app;
    } t_entry;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic shift;
        logic write;
        logic hit_clr;
        logic hit_run;
    } t_cell_ctrl;

endpackage

// ----- design/tdq_cell.sv -----
// tdq_cell: one queue slot holding an entry and a duplicate-hit flag
// depends on tdq_pkg
module tdq_cell (
    input  logic                       i_clk,
    input  tdq_pkg::t_cell_ctrl        i_ctrl,
    input  logic [tdq_pkg::CNT_W-1:0]  i_index,
    input  logic [tdq_pkg::CNT_W-1:0]  i_count,
    input  tdq_pkg::t_entry            i_wr_entry,
    input  tdq_pkg::t_entry            i_upper_entry,
    input  logic                       i_upper_hit,
    input  logic [15:0]                i_key_id,
    input  logic [31:0]                i_key_seq,
    output tdq_pkg::t_entry            o_entry,
    output logic                       o_hit
);
    import tdq_pkg::*;

    t_entry r_entry;
    logic   r_hit;
    logic   w_match;

    assign w_match = (r_entry.event_id == i_key_id) && (r_entry.sequence_num == i_key_seq);

    // tail write lands in the cell whose place equals the fill count
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && (i_index == i_count)) begin
            r_entry <= i_wr_entry;
        end else if (i_ctrl.shift) begin
            r_entry <= i_upper_entry;
        end
    end

    // hit flags ripple toward the head one cell per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.hit_clr) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.hit_run) begin
            r_hit <= w_match | i_upper_hit;
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ----- design/tdq_chain.sv -----
// tdq_chain: row of tdq_cell slots, head at place zero
// depends on tdq_pkg and tdq_cell
module tdq_chain (
    input  logic                       i_clk,
    input  tdq_pkg::t_cell_ctrl        i_ctrl,
    input  logic [tdq_pkg::CNT_W-1:0]  i_count,
    input  tdq_pkg::t_entry            i_wr_entry,
    input  logic [15:0]                i_key_id,
    input  logic [31:0]                i_key_seq,
    output tdq_pkg::t_entry            o_head_entry,
    output logic                       o_head_hit
);
    import tdq_pkg::*;

    t_entry w_entry [CELL_COUNT];
    logic   w_hit   [CELL_COUNT];

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        t_entry w_upper_entry;
        logic   w_upper_hit;

        // the last cell has nothing above it
        if (k == CELL_COUNT - 1) begin : g_top
            assign w_upper_entry = '0;
            assign w_upper_hit   = 1'b0;
        end else begin : g_mid
            assign w_upper_entry = w_entry[k+1];
            assign w_upper_hit   = w_hit[k+1];
        end

        tdq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (i_ctrl),
            .i_index       (CNT_W'(k)),
            .i_count       (i_count),
            .i_wr_entry    (i_wr_entry),
            .i_upper_entry (w_upper_entry),
            .i_upper_hit   (w_upper_hit),
            .i_key_id      (i_key_id),
            .i_key_seq     (i_key_seq),
            .o_entry       (w_entry[k]),
            .o_hit         (w_hit[k])
        );
    end

    assign o_head_entry = w_entry[0];
    assign o_head_hit   = w_hit[0];

endmodule

// ----- design/timer_dedup_event_queue.sv -----
// timer_dedup_event_queue: event queue with timer duplicate suppression
// depends on tdq_pkg and tdq_chain
//
// usage
//   input channel: one word per post (kind 0) or take (kind 1), taken when
//   i_in_valid is high and o_in_stall low; o_in_stall stays high while a word
//   is being worked on, so the block handles one word at a time
//   output channel: exactly one result word per input word, held in an output
//   register until taken (o_out_valid high, i_out_stall low); while it waits
//   the next input word is already accepted and worked on
//   config: apb port, timer id at byte address 0, exit id at address 4
// timing
//   entries sit in a row of cells with the head in cell zero; a take shifts
//   the row down by one, a post writes the cell at the fill count
//   a timer post scans by letting per-cell hit flags ripple toward the head,
//   one cell per cycle, across all held entries (0..126 of them)
// reset
//   clears fill count, state machine and output valid; ids return to 1 and 2
//   entry contents are not cleared, only held entries are ever read
module timer_dedup_event_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tdq_pkg::t_in_word  i_in_word,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tdq_pkg::t_out_word o_out_word,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tdq_pkg::*;

    // state
    t_state             r_state, n_state;
    t_in_word           r_in;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_scan_cnt;
    logic               r_scan_need;
    logic [15:0]        r_timer_id;
    logic [15:0]        r_exit_id;
    logic               r_out_valid;
    t_out_word          r_out_word, n_out_word;

    // control
    logic               w_in_acc;
    logic               w_fin_fire;
    logic               w_full;
    logic               w_need_scan;
    logic               w_cfg_wr;
    t_cell_ctrl         w_ctrl;
    t_entry             w_wr_entry;
    t_entry             w_head;
    logic               w_head_hit;
    logic               w_bad_ptr;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(CELL_COUNT));
    // a timer post into a queue with room must look for a match
    assign w_need_scan = (r_in.kind == KIND_POST) && (r_in.event_id != 16'd0) && !w_full
                         && (r_in.event_id == r_timer_id);

    // pointer payload with null handle or non-positive size stores zeros
    assign w_bad_ptr = (r_in.data_format == FMT_POINTER) && ((r_in.first_word == 32'd0)
                       || (r_in.second_word == 32'd0) || r_in.second_word[31]);

    always_comb begin
        w_wr_entry.event_id     = r_in.event_id;
        w_wr_entry.sequence_num = r_in.sequence_num;
        w_wr_entry.first_word   = w_bad_ptr ? 32'd0 : r_in.first_word;
        w_wr_entry.second_word  = w_bad_ptr ? 32'd0 : r_in.second_word;
        w_wr_entry.category     = r_in.category;
        w_wr_entry.data_format  = r_in.data_format;
        w_wr_entry.dest_app     = r_in.dest_app;
    end

    // cell row
    tdq_chain u_chain (
        .i_clk        (i_clk),
        .i_ctrl       (w_ctrl),
        .i_count      (r_count),
        .i_wr_entry   (w_wr_entry),
        .i_key_id     (r_timer_id),
        .i_key_seq    (r_in.sequence_num),
        .o_head_entry (w_head),
        .o_head_hit   (w_head_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan_cnt == '0) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_fin_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the state machine and result decode
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_fin_fire = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
        w_ctrl     = '0;
        n_count    = r_count;
        n_out_word = '0;

        w_ctrl.hit_clr = (r_state == S_EVAL);
        w_ctrl.hit_run = (r_state == S_SCAN) && (r_scan_cnt != '0);

        if (r_in.kind == KIND_POST) begin
            priority if (r_in.event_id == 16'd0) begin
                n_out_word.status = ST_BAD_ID;
            end else if (w_full) begin
                n_out_word.status = ST_FULL;
            end else if (r_scan_need && w_head_hit) begin
                n_out_word.status = ST_DUP;
            end else begin
                n_out_word.status = ST_POSTED;
                w_ctrl.write      = w_fin_fire;
                n_count           = r_count + CNT_W'(1);
            end
        end else if (r_count == '0) begin
            n_out_word.status = ST_EMPTY;
        end else begin
            n_out_word.status           = (w_head.event_id == r_exit_id) ? ST_EXIT : ST_TAKEN;
            n_out_word.out_event_id     = w_head.event_id;
            n_out_word.out_sequence_num = w_head.sequence_num;
            n_out_word.out_first_word   = w_head.first_word;
            n_out_word.out_second_word  = w_head.second_word;
            n_out_word.out_category     = w_head.category;
            n_out_word.out_data_format  = w_head.data_format;
            n_out_word.out_dest_app     = w_head.dest_app;
            w_ctrl.shift                = w_fin_fire;
            n_count                     = r_count - CNT_W'(1);
        end
        n_out_word.occupancy = 7'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input word, scan length and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_word;
        end
        if (r_state == S_EVAL) begin
            r_scan_need <= w_need_scan;
            r_scan_cnt  <= w_need_scan ? r_count : '0;
        end else if (w_ctrl.hit_run) begin
            r_scan_cnt <= r_scan_cnt - CNT_W'(1);
        end
        if (w_fin_fire) begin
            r_out_word <= n_out_word;
        end
    end

    // config registers, decoded on the word address bit
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_id <= 16'd1;
            r_exit_id  <= 16'd2;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_TIMER_ID: r_timer_id <= pwdata[15:0];
                REG_EXIT_ID:  r_exit_id  <= pwdata[15:0];
                default:      r_timer_id <= r_timer_id;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_EXIT_ID) ? {16'd0, r_exit_id} : {16'd0, r_timer_id};
    assign pready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CELL_COUNT))
        else $error("fill count beyond cell row");

    a_post_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_fire && (r_in.kind == KIND_POST) && (n_out_word.status == ST_POSTED))
        |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("successful post did not grow the queue");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_cnt <= r_count))
        else $error("scan runs past held entries");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> !(r_state == S_FINISH))
        else $error("word accepted while a result is pending");

endmodule

// ----- verif/tb_timer_dedup_event_queue.sv -----
// tb_timer_dedup_event_queue: self-checking bench for the timer event queue
// posts and takes words with random gaps and stalls and predicts every result word
// depends on tdq_pkg and timer_dedup_event_queue
module tb_timer_dedup_event_queue;
    import tdq_pkg::*;

    // generous fixed bound, well above the slowest legal run
    localparam int LIMIT_TIME      = 5_000_000;
    // settling wait after the final drain, longer than any timer post scan
    localparam int SETTLE_CYCLES   = 140;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_PRINTED     = 40;

    localparam logic [2:0]  ADDR_TIMER_ID  = {REG_TIMER_ID, 2'b00};
    localparam logic [2:0]  ADDR_EXIT_ID   = {REG_EXIT_ID, 2'b00};
    localparam logic [15:0] TIMER_ID_RESET = 16'd1;
    localparam logic [15:0] EXIT_ID_RESET  = 16'd2;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predicted queue contents and register copies
    t_entry      queued_entries[$];
    logic [15:0] timer_id_reg;
    logic [15:0] exit_id_reg;

    // result words still owed by the block, oldest first
    t_out_word   expected_results[$];

    int mismatch_count = 0;
    bit calm = 1'b0;       // no random gaps or stalls while set; a requested hold-off still applies
    int hold_request = 0;  // asks the receiver for a long hold-off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    timer_dedup_event_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // queue behavior: one result word per accepted word
    function automatic t_out_word queue_step(input t_in_word w);
        t_out_word r;
        t_entry    e;
        bit        dup;
        r   = '0;
        dup = 1'b0;
        if (w.kind == KIND_POST) begin
            // bad id wins over full, full wins over the duplicate scan
            if (w.event_id == 16'h0) begin
                r.status = ST_BAD_ID;
            end else if (queued_entries.size() == CELL_COUNT) begin
                r.status = ST_FULL;
            end else begin
                if (w.event_id == timer_id_reg) begin
                    foreach (queued_entries[i])
                        if (queued_entries[i].event_id == timer_id_reg &&
                            queued_entries[i].sequence_num == w.sequence_num)
                            dup = 1'b1;
                end
                if (dup) begin
                    r.status = ST_DUP;
                end else begin
                    e.event_id     = w.event_id;
                    e.sequence_num = w.sequence_num;
                    e.first_word   = w.first_word;
                    e.second_word  = w.second_word;
                    e.category     = w.category;
                    e.data_format  = w.data_format;
                    e.dest_app     = w.dest_app;
                    // pointer payload without data or with non-positive size is emptied
                    if (w.data_format == FMT_POINTER &&
                        (w.first_word == 32'h0 || $signed(w.second_word) <= 0)) begin
                        e.first_word  = '0;
                        e.second_word = '0;
                    end
                    queued_entries.push_back(e);
                    r.status = ST_POSTED;
                end
            end
        end else if (queued_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            e = queued_entries.pop_front();
            r.status           = (e.event_id == exit_id_reg) ? ST_EXIT : ST_TAKEN;
            r.out_event_id     = e.event_id;
            r.out_sequence_num = e.sequence_num;
            r.out_first_word   = e.first_word;
            r.out_second_word  = e.second_word;
            r.out_category     = e.category;
            r.out_data_format  = e.data_format;
            r.out_dest_app     = e.dest_app;
        end
        r.occupancy = 7'(queued_entries.size());
        return r;
    endfunction

    // result checker: every accepted result word against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing outstanding",
                                32'(o_out_word.status), '0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(o_out_word.status), 32'(want.status));
                check_field("event id", 32'(o_out_word.out_event_id),
                            32'(want.out_event_id));
                check_field("sequence", o_out_word.out_sequence_num, want.out_sequence_num);
                check_field("first word", o_out_word.out_first_word, want.out_first_word);
                check_field("second word", o_out_word.out_second_word,
                            want.out_second_word);
                check_field("category", 32'(o_out_word.out_category),
                            32'(want.out_category));
                check_field("format", 32'(o_out_word.out_data_format),
                            32'(want.out_data_format));
                check_field("dest app", o_out_word.out_dest_app, want.out_dest_app);
                check_field("occupancy", 32'(o_out_word.occupancy), 32'(want.occupancy));
            end
        end
    end

    // receiver: random stall after each taken word, plus an occasional long hold-off
    initial begin : result_receiver
        int stall_left;
        int hold_left;
        bit taken;
        stall_left  = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            taken = o_out_valid && !i_out_stall;
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (taken)
                stall_left = calm ? 0 : $urandom_range(0, 5);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // offer one word after a random gap; predict it once accepted
    task automatic send_word(input t_in_word w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(queue_step(w));
    endtask

    // sender pauses until every outstanding result word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one id register (junk in the unused upper half) and read it back
    task automatic write_register(input logic reg_sel, input logic [15:0] value);
        logic [31:0] rdata;
        logic [2:0]  addr;
        addr = {reg_sel, 2'b00};
        apb_access(1'b1, addr, {16'($urandom), value}, rdata);
        if (reg_sel == REG_TIMER_ID)
            timer_id_reg = value;
        else
            exit_id_reg = value;
        apb_access(1'b0, addr, '0, rdata);
        check_field("register readback", rdata, {16'h0, value});
    endtask

    function automatic t_in_word make_post(input logic [15:0] id, input logic [31:0] seq,
                                           input logic [31:0] wa, input logic [31:0] wb,
                                           input logic [7:0] cat, input logic fmt,
                                           input logic [31:0] app);
        t_in_word w;
        w.kind         = KIND_POST;
        w.event_id     = id;
        w.sequence_num = seq;
        w.first_word   = wa;
        w.second_word  = wb;
        w.category     = cat;
        w.data_format  = fmt;
        w.dest_app     = app;
        return w;
    endfunction

    // random word; ids lean on the timer and exit ids, sequences on a small set
    function automatic t_in_word random_word(input int post_pct);
        t_in_word w;
        int       pick;
        w.kind = ($urandom_range(0, 99) < post_pct) ? KIND_POST : KIND_TAKE;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            w.event_id = '0;
        else if (pick < 6)
            w.event_id = timer_id_reg;
        else if (pick < 8)
            w.event_id = exit_id_reg;
        else
            w.event_id = 16'($urandom);
        w.sequence_num = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : 32'($urandom);
        w.first_word   = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom);
        w.second_word  = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom);
        w.category     = 8'($urandom);
        w.data_format  = 1'($urandom);
        w.dest_app     = $urandom;
        return w;
    endfunction

    function automatic logic [15:0] plain_id();
        logic [15:0] id;
        do id = 16'($urandom); while (id == 16'h0 || id == timer_id_reg);
        return id;
    endfunction

    task automatic test_register_reset();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_TIMER_ID, '0, rdata);
        check_field("timer id after reset", rdata, {16'h0, TIMER_ID_RESET});
        apb_access(1'b0, ADDR_EXIT_ID, '0, rdata);
        check_field("exit id after reset", rdata, {16'h0, EXIT_ID_RESET});
    endtask

    // field extremes, every status but full and the payload special cases, default ids
    task automatic test_directed_cases();
        send_word(random_word(0));                                    // take from empty
        send_word(make_post(16'h0, '1, '1, '1, '1, 1'b1, '1));        // bad id
        send_word(make_post(16'hFFFF, '1, '1, '1, '1, 1'b0, '1));     // all ones kept
        send_word(make_post(timer_id_reg, '0, '0, '0, '0, 1'b0, '0)); // timer, all zero
        send_word(make_post(timer_id_reg, '0, 32'h5, 32'h6, 8'h1, 1'b0, 32'h7)); // duplicate
        send_word(make_post(timer_id_reg, '1, 32'h11, 32'h22, 8'h33, 1'b0, 32'h44));
        send_word(make_post(16'h5, '0, 32'h55, 32'h66, 8'h77, 1'b0, 32'h88)); // same seq, no timer
        // pointer payloads: null handle, zero size, negative size, then a good one
        send_word(make_post(16'h10, 32'h1, 32'h0, 32'h5, 8'h80, 1'b1, 32'h1));
        send_word(make_post(16'h11, 32'h2, 32'h7, 32'h0, 8'h81, 1'b1, 32'h2));
        send_word(make_post(16'h12, 32'h3, 32'h7, 32'h8000_0000, 8'h82, 1'b1, 32'h3));
        send_word(make_post(16'h13, 32'h4, '1, 32'h7FFF_FFFF, 8'hFF, 1'b1, 32'h4));
        send_word(make_post(exit_id_reg, 32'h5, 32'h0, 32'h9, 8'h0, 1'b0, 32'h5)); // exit entry
        repeat (10) send_word(random_word(0));  // nine entries, then empty again
        send_word(make_post(timer_id_reg, '0, 32'h1, 32'h2, 8'h3, 1'b0, 32'h4)); // seq 0 gone
        send_word(random_word(0));
    endtask

    // fill the whole row under a long receiver hold-off, then hit full and the scan ends
    task automatic test_full_queue_pressure();
        logic [15:0] id;
        wait_drained();
        hold_request = HOLD_OFF_CYCLES;
        calm = 1'b1;
        for (int k = 0; k < CELL_COUNT; k++) begin
            if (k % 3 == 0)
                id = timer_id_reg;
            else if (k == 61)
                id = exit_id_reg;
            else
                id = plain_id();
            send_word(make_post(id, 32'(k), $urandom, $urandom, 8'($urandom),
                                1'($urandom), $urandom));
        end
        // full is reported even when the timer sequence is also a duplicate
        send_word(make_post(timer_id_reg, 32'd0, $urandom, $urandom, 8'h0, 1'b0, $urandom));
        // bad id is reported before full
        send_word(make_post(16'h0, 32'd1, $urandom, $urandom, 8'h0, 1'b0, $urandom));
        send_word(random_word(0));  // pops the timer entry with sequence 0
        // duplicate at the tail end and near the head of the scan
        send_word(make_post(timer_id_reg, 32'(CELL_COUNT - 1), $urandom, $urandom,
                            8'h0, 1'b0, $urandom));
        send_word(make_post(timer_id_reg, 32'd3, $urandom, $urandom, 8'h0, 1'b0, $urandom));
        send_word(make_post(timer_id_reg, 32'd0, $urandom, $urandom, 8'hA5, 1'b0, $urandom));
        calm = 1'b0;
        repeat (CELL_COUNT + 1) send_word(random_word(0));
    endtask

    // one phase of random words under one register setting, written while idle
    task automatic run_phase(input logic [15:0] timer_id, input logic [15:0] exit_id,
                             input int post_pct, input int count, input bit quiet);
        wait_drained();
        write_register(REG_TIMER_ID, timer_id);
        write_register(REG_EXIT_ID, exit_id);
        calm = quiet;
        repeat (count) send_word(random_word(post_pct));
        calm = 1'b0;
    endtask

    // extreme settings: zero ids never match, equal timer and exit ids
    task automatic test_register_settings();
        run_phase(16'h0000, 16'h0000, 60, 40, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 85, 60, 1'b0);
        run_phase(16'h0001, 16'hFFFF, 30, 40, 1'b1);
    endtask

    task automatic test_random_traffic();
        repeat (4)
            run_phase(16'($urandom_range(1, 16'hFFFF)), 16'($urandom),
                      $urandom_range(20, 90), 40, $urandom_range(0, 3) == 0);
        run_phase(TIMER_ID_RESET, EXIT_ID_RESET, 10, 40, 1'b0);
    endtask

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        timer_id_reg = TIMER_ID_RESET;
        exit_id_reg  = EXIT_ID_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_directed_cases();
        test_full_queue_pressure();
        test_register_settings();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_TIME);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
design/tdq_pkg.sv
design/tdq_cell.sv
design/tdq_chain.sv
design/timer_dedup_event_queue.sv
verif/tb_timer_dedup_event_queue.sv
